/* hw/rtl/lmb_pkg.sv */
// Shared types, constants and helper functions for the line mark bitmap engine.
package lmb_pkg;

    localparam int LINES      = 256;
    localparam int WORD_BITS  = 32;
    localparam int WORDS      = LINES / WORD_BITS;
    localparam int WORD_IDX_W = $clog2(WORDS);
    localparam int BIT_IDX_W  = $clog2(WORD_BITS);
    localparam int LINE_W     = 9;
    localparam int ACTION_W   = 3;
    localparam int POP_W      = BIT_IDX_W + 1;

    localparam logic [LINE_W-1:0] LINES_C = LINE_W'(LINES);

    // Action codes carried in the input word
    typedef enum logic [ACTION_W-1:0] {
        ACT_CLEAR       = 3'd0,
        ACT_SET_RANGE   = 3'd1,
        ACT_COUNT_SET   = 3'd2,
        ACT_COUNT_HOLES = 3'd3,
        ACT_NEXT_HOLE   = 3'd4
    } action_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic                  load;
        logic                  step;
        logic [WORD_IDX_W-1:0] word;
        logic                  out_load;
    } lmb_cmd_t;

    // Number of set bits in one bitmap word
    function automatic logic [POP_W-1:0] popcount(input logic [WORD_BITS-1:0] v);
        logic [POP_W-1:0] n;
        n = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            n = n + POP_W'(v[i]);
        end
        return n;
    endfunction

    // Index of the lowest set bit (zero when none is set)
    function automatic logic [BIT_IDX_W-1:0] lowest_idx(input logic [WORD_BITS-1:0] v);
        logic [BIT_IDX_W-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = BIT_IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

/* hw/rtl/lmb_ctrl.sv */
// Controller state machine: accepts a word, sequences the word scan, loads the result.
module lmb_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output lmb_pkg::lmb_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t                         state_reg, state_next;
    logic [lmb_pkg::WORD_IDX_W-1:0] word_reg, word_next;
    logic                           m_tvalid_reg, m_tvalid_next;
    logic                           out_free;
    logic                           accept;

    // Output register may take a new result when empty or being drained
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) || ((state_reg == ST_FINISH) && out_free);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;

    // Sequence the scan over the bitmap words
    always_comb begin
        state_next   = state_reg;
        word_next    = word_reg;
        cmd          = '0;
        cmd.word     = word_reg;
        cmd.load     = accept;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_SCAN;
                    word_next  = '0;
                end
            end
            ST_SCAN: begin
                cmd.step  = 1'b1;
                word_next = word_reg + 1'b1;
                if (word_reg == lmb_pkg::WORD_IDX_W'(lmb_pkg::WORDS - 1)) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = accept ? ST_SCAN : ST_IDLE;
                    word_next    = '0;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the result valid until the receiver takes it
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            word_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            word_reg     <= word_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

/* hw/rtl/lmb_dp.sv */
// Datapath: mark bitmap, per-word range masks, counters, hole search and result register.
module lmb_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  lmb_pkg::lmb_cmd_t              cmd,
    input  logic [lmb_pkg::ACTION_W-1:0]   in_action,
    input  logic [lmb_pkg::LINE_W-1:0]     in_range_start,
    input  logic [lmb_pkg::LINE_W-1:0]     in_range_end,
    output logic [lmb_pkg::LINE_W-1:0]     out_line_count,
    output logic                           out_hole_found,
    output logic [lmb_pkg::LINE_W-1:0]     out_hole_start,
    output logic [lmb_pkg::LINE_W-1:0]     out_hole_end
);

    localparam int WB = lmb_pkg::WORD_BITS;
    localparam int LW = lmb_pkg::LINE_W;

    logic [WB-1:0]        bits_reg [lmb_pkg::WORDS];
    lmb_pkg::action_t     act_reg;
    logic [LW-1:0]        start_reg, end_reg;
    logic [LW-1:0]        cnt_reg, cnt_next;
    logic                 found_reg, found_next;
    logic                 ended_reg, ended_next;
    logic [LW-1:0]        hs_reg, hs_next;
    logic [LW-1:0]        he_reg, he_next;
    logic                 carry_reg;
    logic [LW-1:0]        out_cnt_reg, out_hs_reg, out_he_reg;
    logic                 out_found_reg;

    logic [LW-1:0]        end_clip;
    logic [WB-1:0]        cur, in_mask, lt_end, start_bit, prev_m;
    logic [WB-1:0]        holes, cand, stop, lowest, above, stop_hit;
    logic [WB-1:0]        pop_src;
    logic [WB-1:0]        wr_word;
    logic [LW-1:0]        line_of [WB];

    assign end_clip = (in_range_end > lmb_pkg::LINES_C) ? lmb_pkg::LINES_C : in_range_end;

    // Build the range masks for the word under scan
    always_comb begin
        cur = bits_reg[cmd.word];
        for (int i = 0; i < WB; i++) begin
            line_of[i]   = LW'({cmd.word, lmb_pkg::BIT_IDX_W'(i)});
            lt_end[i]    = line_of[i] < end_reg;
            in_mask[i]   = (line_of[i] >= start_reg) && lt_end[i];
            start_bit[i] = line_of[i] == start_reg;
        end
        prev_m  = {cur[WB-2:0], carry_reg};
        holes   = ~cur & (prev_m | start_bit) & in_mask;
        cand    = ~cur & ~prev_m & in_mask;
        stop    = cur | ~lt_end;
        lowest  = cand & (~cand + 1'b1);
        above   = ~(lowest | (lowest - 1'b1));
        stop_hit = stop & above;
        pop_src = (act_reg == lmb_pkg::ACT_COUNT_SET) ? (cur & in_mask) : holes;
    end

    // Advance the count, the hole search or the word write-back by one word; a load resets them
    always_comb begin
        cnt_next   = cnt_reg;
        found_next = found_reg;
        ended_next = ended_reg;
        hs_next    = hs_reg;
        he_next    = he_reg;
        wr_word    = cur;
        if (cmd.load) begin
            cnt_next   = '0;
            found_next = 1'b0;
            ended_next = 1'b0;
            hs_next    = '0;
            he_next    = '0;
        end else if (cmd.step) begin
            case (act_reg)
                lmb_pkg::ACT_CLEAR: begin
                    wr_word = '0;
                end
                lmb_pkg::ACT_SET_RANGE: begin
                    wr_word = cur | in_mask;
                end
                lmb_pkg::ACT_COUNT_SET, lmb_pkg::ACT_COUNT_HOLES: begin
                    cnt_next = cnt_reg + LW'(lmb_pkg::popcount(pop_src));
                end
                lmb_pkg::ACT_NEXT_HOLE: begin
                    if (!found_reg) begin
                        if (|cand) begin
                            found_next = 1'b1;
                            hs_next    = LW'({cmd.word, lmb_pkg::lowest_idx(cand)});
                            if (|stop_hit) begin
                                ended_next = 1'b1;
                                he_next    = LW'({cmd.word, lmb_pkg::lowest_idx(stop_hit)});
                            end
                        end
                    end else if (!ended_reg && (|stop)) begin
                        ended_next = 1'b1;
                        he_next    = LW'({cmd.word, lmb_pkg::lowest_idx(stop)});
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Bitmap words, cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int w = 0; w < lmb_pkg::WORDS; w++) begin
                bits_reg[w] <= '0;
            end
        end else if (cmd.step) begin
            bits_reg[cmd.word] <= wr_word;
        end
    end

    // Item registers, scan accumulators and the result register
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg   <= lmb_pkg::action_t'(in_action);
            start_reg <= in_range_start;
            end_reg   <= end_clip;
            carry_reg <= 1'b0;
        end else if (cmd.step) begin
            carry_reg <= cur[WB-1];
        end
        cnt_reg   <= cnt_next;
        found_reg <= found_next;
        ended_reg <= ended_next;
        hs_reg    <= hs_next;
        he_reg    <= he_next;
        if (cmd.out_load) begin
            out_cnt_reg   <= cnt_reg;
            out_found_reg <= found_reg;
            out_hs_reg    <= found_reg ? hs_reg : '0;
            out_he_reg    <= found_reg ? (ended_reg ? he_reg : end_reg) : '0;
        end
    end

    assign out_line_count = out_cnt_reg;
    assign out_hole_found = out_found_reg;
    assign out_hole_start = out_hs_reg;
    assign out_hole_end   = out_he_reg;

endmodule

/* hw/rtl/line_mark_bitmap_engine.sv */
// Top level of the line mark bitmap engine: controller, datapath and stream ports.
//
// Keeps one mark bit for each of 256 heap lines and runs one action per input word:
// clear the map, mark a line range, count marked lines, count holes, or find the
// next usable hole at or after a start line.
// Input channel s_*: one word per action; output channel m_*: one result word per
// action, in order.
// Each action walks the eight 32-bit bitmap words, one per cycle, through a single
// read/write port of the bitmap. Once an accepted word has been scanned, its
// result is loaded into the result register that drives m_tdata; a new word is
// taken in the cycle the result is loaded, while the output side keeps up.
// The result register lets the next action scan while an earlier result waits; if
// the receiver holds m_tready low, the finished action waits in its last state and
// s_tready stays low until the result register frees up.
// A synchronous reset (aresetn low) empties both channels and clears every mark bit.
module line_mark_bitmap_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // action[2:0], range_start[11:3], range_end[20:12], zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // line_count[8:0], hole_found[9], hole_start[18:10],
                                   // hole_end[27:19], zero
);

    localparam int LW = lmb_pkg::LINE_W;
    localparam int AW = lmb_pkg::ACTION_W;

    lmb_pkg::lmb_cmd_t cmd;
    logic [LW-1:0]     line_count, hole_start, hole_end;
    logic              hole_found;

    lmb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    lmb_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .in_action      (s_tdata[AW-1:0]),
        .in_range_start (s_tdata[AW+LW-1:AW]),
        .in_range_end   (s_tdata[AW+2*LW-1:AW+LW]),
        .out_line_count (line_count),
        .out_hole_found (hole_found),
        .out_hole_start (hole_start),
        .out_hole_end   (hole_end)
    );

    // Pack the result word, lowest field first
    assign m_tdata = {4'b0, hole_end, hole_start, hole_found, line_count};

endmodule

/* hw/rtl/lmb_checker.sv */
// Port checker for the line mark bitmap engine, bound to the top level.
module lmb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [23:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // Hold a stalled result word steady
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // Drop s_tready for the scan after an accepted word
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken during a scan");

    // A missing hole reports zero bounds
    a_no_hole_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[9] |-> m_tdata[18:10] == 9'd0 && m_tdata[27:19] == 9'd0)
        else $error("hole bounds set without a hole");

    // A found hole is never empty
    a_hole_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[9] |-> m_tdata[18:10] < m_tdata[27:19])
        else $error("hole end not above hole start");

    // Counts never exceed the line total and the unused top bits stay zero
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[8:0] <= 9'd256 && m_tdata[31:28] == 4'd0)
        else $error("count out of range");

endmodule

bind line_mark_bitmap_engine lmb_checker u_lmb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* tb/sv/line_mark_bitmap_engine_tb.sv */
// Self-checking testbench for the line mark bitmap engine: directed table, then random words.
module line_mark_bitmap_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_LINES       = lmb_pkg::LINES;
    localparam int RANDOM_WORDS  = 750;
    localparam int HOLD_CYCLES   = 300;
    localparam int WATCHDOG_MAX  = 5000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int NUM_DIRECTED  = 25;
    localparam int MAX_REPORTS   = 10;

    // Action codes the block must ignore
    localparam logic [lmb_pkg::ACTION_W-1:0] ACT_RESERVED_LO = 3'd5;
    localparam logic [lmb_pkg::ACTION_W-1:0] ACT_RESERVED_HI = 3'd7;

    typedef struct packed {
        logic [lmb_pkg::LINE_W-1:0] line_count;
        logic                       hole_found;
        logic [lmb_pkg::LINE_W-1:0] hole_start;
        logic [lmb_pkg::LINE_W-1:0] hole_end;
    } line_result_t;

    typedef struct {
        logic [lmb_pkg::ACTION_W-1:0] act;
        int                           first;
        int                           last;
        bit                           fixed;
        line_result_t                 want;
    } stim_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // action[2:0], range_start[11:3], range_end[20:12], zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // line_count[8:0], hole_found[9], hole_start[18:10],
                                  // hole_end[27:19], zero

    logic [N_LINES-1:0] mark_shadow;
    line_result_t       pending_results [$];
    stim_row_t          directed_rows [NUM_DIRECTED];
    int                 error_count     = 0;
    int                 source_idle_pct = 0;
    int                 sink_idle_pct   = 0;
    int                 hold_requests   = 0;

    line_mark_bitmap_engine DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Marked lines in [first, last)
    function automatic int marked_in_range(input int first, input int last);
        int n;
        n = 0;
        for (int i = first; i < last; i++) begin
            n += int'(mark_shadow[i]);
        end
        return n;
    endfunction

    // Maximal unmarked runs in [first, last), the line before first taken as marked
    function automatic int runs_in_range(input int first, input int last);
        int n;
        bit prev;
        n = 0;
        prev = 1'b1;
        for (int i = first; i < last; i++) begin
            if (!mark_shadow[i] && prev) begin
                n++;
            end
            prev = mark_shadow[i];
        end
        return n;
    endfunction

    // First usable hole, skipping a free line that directly follows a marked one
    function automatic bit find_usable_hole(input int first, input int last,
                                            output int hs, output int he);
        int i;
        hs = 0;
        he = 0;
        i = first;
        while (i < last) begin
            while (i < last && mark_shadow[i]) i++;
            if (i >= last) return 1'b0;
            if (i > 0 && mark_shadow[i-1]) begin
                i++;
                if (i >= last) return 1'b0;
                if (mark_shadow[i]) continue;
            end
            hs = i;
            while (i < last && !mark_shadow[i]) i++;
            he = i;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Update the line map for one word and work out its result
    function automatic line_result_t apply_line_action(
        input logic [lmb_pkg::ACTION_W-1:0] act, input int first, input int last);
        line_result_t r;
        int hs, he;
        r = '0;
        if (last > N_LINES) last = N_LINES;
        case (act)
            lmb_pkg::ACT_CLEAR: mark_shadow = '0;
            lmb_pkg::ACT_SET_RANGE: begin
                for (int i = first; i < last; i++) mark_shadow[i] = 1'b1;
            end
            lmb_pkg::ACT_COUNT_SET:
                r.line_count = lmb_pkg::LINE_W'(marked_in_range(first, last));
            lmb_pkg::ACT_COUNT_HOLES:
                r.line_count = lmb_pkg::LINE_W'(runs_in_range(first, last));
            lmb_pkg::ACT_NEXT_HOLE: begin
                if (find_usable_hole(first, last, hs, he)) begin
                    r.hole_found = 1'b1;
                    r.hole_start = lmb_pkg::LINE_W'(hs);
                    r.hole_end   = lmb_pkg::LINE_W'(he);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) $display("ERROR %0t: %s", $realtime, msg);
    endtask

    // Offer one word, wait for it to be taken, then record what it should give
    task automatic push_word(input logic [lmb_pkg::ACTION_W-1:0] act, input int first,
                             input int last, input bit fixed, input line_result_t want);
        line_result_t r;
        while ($urandom_range(0, 99) < source_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, lmb_pkg::LINE_W'(last), lmb_pkg::LINE_W'(first), act};
        do @(posedge aclk); while (!s_tready);
        r = apply_line_action(act, first, last);
        pending_results.push_back(fixed ? want : r);
    endtask

    // Receiver: random back-pressure, plus a long hold when one is requested
    always @(posedge aclk) begin : sink_ready
        int hold_left;
        int hold_seen;
        if (!aresetn) begin
            hold_left = 0;
            hold_seen = hold_requests;
            m_tready <= 1'b0;
        end else if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // Compare each result word with the oldest expectation
    always @(posedge aclk) begin : result_check
        line_result_t want;
        line_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[8:0], m_tdata[9], m_tdata[18:10], m_tdata[27:19]};
            if (pending_results.size() == 0) begin
                note_error($sformatf("result word with nothing expected: %h", m_tdata));
            end else begin
                want = pending_results.pop_front();
                if (got.line_count != want.line_count)
                    note_error($sformatf("line_count exp %0d got %0d",
                                         want.line_count, got.line_count));
                if (got.hole_found != want.hole_found)
                    note_error($sformatf("hole_found exp %0d got %0d",
                                         want.hole_found, got.hole_found));
                if (got.hole_start != want.hole_start)
                    note_error($sformatf("hole_start exp %0d got %0d",
                                         want.hole_start, got.hole_start));
                if (got.hole_end != want.hole_end)
                    note_error($sformatf("hole_end exp %0d got %0d",
                                         want.hole_end, got.hole_end));
            end
        end
    end

    // Watchdog: end the run if neither channel moves a word for too long
    always @(posedge aclk) begin : watchdog
        int quiet;
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= WATCHDOG_MAX) begin
                $display("line_mark_bitmap_engine_tb: done, errors");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int pick;
        int first;
        int last;
        int span;
        logic [lmb_pkg::ACTION_W-1:0] act;

        // Directed rows: fixed rows carry their result, the rest use the predictor
        directed_rows = '{
            // empty map after reset
            '{lmb_pkg::ACT_COUNT_SET,   0,   256, 1'b1, '{9'd0,   1'b0, 9'd0, 9'd0}},
            '{lmb_pkg::ACT_COUNT_HOLES, 0,   256, 1'b1, '{9'd1,   1'b0, 9'd0, 9'd0}},
            '{lmb_pkg::ACT_NEXT_HOLE,   0,   256, 1'b1, '{9'd0,   1'b1, 9'd0, 9'd256}},
            // full map
            '{lmb_pkg::ACT_SET_RANGE,   0,   256, 1'b1, '{9'd0,   1'b0, 9'd0, 9'd0}},
            '{lmb_pkg::ACT_COUNT_SET,   0,   256, 1'b1, '{9'd256, 1'b0, 9'd0, 9'd0}},
            '{lmb_pkg::ACT_COUNT_HOLES, 0,   256, 1'b1, '{9'd0,   1'b0, 9'd0, 9'd0}},
            '{lmb_pkg::ACT_NEXT_HOLE,   0,   256, 1'b1, '{9'd0,   1'b0, 9'd0, 9'd0}},
            // clear ignores its range
            '{lmb_pkg::ACT_CLEAR,       17,  3,   1'b1, '{9'd0,   1'b0, 9'd0, 9'd0}},
            '{lmb_pkg::ACT_SET_RANGE,   10,  20,  1'b0, '0},
            // skip the free start line that directly follows a marked one
            '{lmb_pkg::ACT_NEXT_HOLE,   20,  256, 1'b0, '0},
            '{lmb_pkg::ACT_NEXT_HOLE,   0,   256, 1'b1, '{9'd0,   1'b1, 9'd0, 9'd10}},
            '{lmb_pkg::ACT_SET_RANGE,   21,  22,  1'b0, '0},
            // skip lands on a marked line, then skip runs off the end
            '{lmb_pkg::ACT_NEXT_HOLE,   20,  22,  1'b0, '0},
            '{lmb_pkg::ACT_NEXT_HOLE,   20,  21,  1'b0, '0},
            '{lmb_pkg::ACT_COUNT_HOLES, 5,   30,  1'b0, '0},
            '{lmb_pkg::ACT_COUNT_SET,   0,   256, 1'b0, '0},
            // empty ranges
            '{lmb_pkg::ACT_COUNT_SET,   50,  50,  1'b1, '{9'd0,   1'b0, 9'd0, 9'd0}},
            '{lmb_pkg::ACT_COUNT_HOLES, 100, 40,  1'b1, '{9'd0,   1'b0, 9'd0, 9'd0}},
            '{lmb_pkg::ACT_NEXT_HOLE,   256, 256, 1'b1, '{9'd0,   1'b0, 9'd0, 9'd0}},
            '{lmb_pkg::ACT_SET_RANGE,   200, 100, 1'b0, '0},
            // top of the block
            '{lmb_pkg::ACT_SET_RANGE,   250, 256, 1'b0, '0},
            '{lmb_pkg::ACT_NEXT_HOLE,   255, 256, 1'b1, '{9'd0,   1'b0, 9'd0, 9'd0}},
            '{lmb_pkg::ACT_COUNT_SET,   240, 256, 1'b0, '0},
            // unused action codes
            '{ACT_RESERVED_LO,          0,   256, 1'b1, '{9'd0,   1'b0, 9'd0, 9'd0}},
            '{ACT_RESERVED_HI,          256, 0,   1'b1, '{9'd0,   1'b0, 9'd0, 9'd0}}
        };

        mark_shadow = '0;
        source_idle_pct = 22;
        sink_idle_pct   = 78;

        // Hold reset, then release it
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[k]) begin
            push_word(directed_rows[k].act, directed_rows[k].first, directed_rows[k].last,
                      directed_rows[k].fixed, directed_rows[k].want);
        end

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            // Idling phases: sender light, then receiver light, then none plus one long receiver hold
            if (n == RANDOM_WORDS / 3) begin
                source_idle_pct = 78;
                sink_idle_pct   = 22;
            end else if (n == 2 * RANDOM_WORDS / 3) begin
                source_idle_pct = 0;
                sink_idle_pct   = 0;
                hold_requests++;
            end

            pick = $urandom_range(0, 99);
            if (pick < 6)       act = lmb_pkg::ACT_CLEAR;
            else if (pick < 32) act = lmb_pkg::ACT_SET_RANGE;
            else if (pick < 50) act = lmb_pkg::ACT_COUNT_SET;
            else if (pick < 68) act = lmb_pkg::ACT_COUNT_HOLES;
            else if (pick < 96) act = lmb_pkg::ACT_NEXT_HOLE;
            else act = lmb_pkg::ACTION_W'(ACT_RESERVED_LO + $urandom_range(0, 2));

            // Mostly short marks and wide queries; some empty or arbitrary ranges
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                first = $urandom_range(0, N_LINES);
                last  = $urandom_range(0, N_LINES);
            end else if (pick == 1) begin
                last  = $urandom_range(0, N_LINES);
                first = $urandom_range(last, N_LINES);
            end else begin
                first = $urandom_range(0, N_LINES - 1);
                span  = (act == lmb_pkg::ACT_SET_RANGE) ? $urandom_range(1, 24)
                                                        : $urandom_range(1, N_LINES);
                last  = (first + span > N_LINES) ? N_LINES : first + span;
            end
            push_word(act, first, last, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        // Drain the outstanding results, then let the block settle
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0 && pending_results.size() == 0) begin
            $display("line_mark_bitmap_engine_tb: done, clean");
        end else begin
            $display("line_mark_bitmap_engine_tb: done, errors");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/lmb_pkg.sv
hw/rtl/lmb_ctrl.sv
hw/rtl/lmb_dp.sv
hw/rtl/line_mark_bitmap_engine.sv
hw/rtl/lmb_checker.sv
tb/sv/line_mark_bitmap_engine_tb.sv
